FILE: design/clipped_rectangle_draw_engine_core_defines.svh
// Assertion macros shared by the draw engine modules.
`ifndef CLIPPED_RECTANGLE_DRAW_ENGINE_CORE_DEFINES_SVH
`define CLIPPED_RECTANGLE_DRAW_ENGINE_CORE_DEFINES_SVH
`ifndef SYNTH
`define CRDE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CRDE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CRDE_ASSERT(label, prop, msg)
`define CRDE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: design/crde_pkg.sv
package crde_pkg;

	localparam int CMD_W       = 2;
	localparam int FIELD_W     = 12;
	localparam int COLOR_W     = 16;
	// field plus field, wide enough for origin + size
	localparam int SUM_W       = FIELD_W + 1;
	// holds any clipped coordinate up to the largest canvas (1024)
	localparam int COORD_W     = 11;
	localparam int QUEUE_DEPTH = 2;

	localparam int DEF_CANVAS_COLS = 320;
	localparam int DEF_CANVAS_ROWS = 240;

	typedef enum logic [CMD_W-1:0] {
		CMD_FILL   = 2'd0,
		CMD_BORDER = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		OP_SKIP  = 2'd0,
		OP_PAINT = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	// one unit of back-end work: a clipped span rectangle, a pixel read or nothing
	typedef struct packed {
		op_t                op;
		logic               last;
		logic               outside;
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] y1;
		logic [COLOR_W-1:0] color;
	} job_t;

endpackage

FILE: design/clipped_rectangle_draw_engine_core.sv
// Rectangle fill and outline engine over a CANVAS_COLS x CANVAS_ROWS frame store of
// 16-bit pixels kept row by row in one single-port-write, registered-read RAM. Each
// command beat (cmd, origin, size, colour) returns exactly one result beat, in order:
// fill and border give read_color and out_of_canvas zero, a read gives the stored
// pixel, or out_of_canvas one when the position lies off the canvas. A zero width or
// height draws nothing, and every span is clipped to the canvas. After reset the
// engine sweeps the whole store to zero, one pixel a cycle, and in_ready stays low until
// the sweep is done. The front end takes one
// command at a time and breaks it into jobs: one clipped rectangle for a fill, four
// clipped edges (top, bottom, left, right) for a border, one lookup for a read; a
// two-entry queue hands them to the back end, which writes one pixel per cycle
// through the RAM write port. A paint job passes through the base and paint states,
// an on-canvas read through base, read issue and read capture; skipped jobs and
// off-canvas reads go straight on from idle. The last job of a command ends in the
// done state. The result waits in an output register, so a stalled consumer holds
// the back end in the done state, and the queued work waits behind it.
module clipped_rectangle_draw_engine_core #(
	parameter int CANVAS_COLS = crde_pkg::DEF_CANVAS_COLS,
	parameter int CANVAS_ROWS = crde_pkg::DEF_CANVAS_ROWS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [crde_pkg::CMD_W-1:0]   cmd,
	input  logic [crde_pkg::FIELD_W-1:0] origin_x,
	input  logic [crde_pkg::FIELD_W-1:0] origin_y,
	input  logic [crde_pkg::FIELD_W-1:0] rect_width,
	input  logic [crde_pkg::FIELD_W-1:0] rect_height,
	input  logic [crde_pkg::COLOR_W-1:0] paint_color,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [crde_pkg::COLOR_W-1:0] read_color,
	output logic                         out_of_canvas
);

	// front to queue
	logic           push;
	logic           push_ready;
	crde_pkg::job_t push_job;
	// queue to back
	logic           pop_valid;
	logic           pop;
	crde_pkg::job_t pop_job;
	// hold off new commands while the store is being cleared
	logic           clearing;

	crde_front #(
		.CANVAS_COLS(CANVAS_COLS),
		.CANVAS_ROWS(CANVAS_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.clearing   (clearing),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.origin_x   (origin_x),
		.origin_y   (origin_y),
		.rect_width (rect_width),
		.rect_height(rect_height),
		.paint_color(paint_color),
		.push       (push),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	// decouple classification from painting: each side stalls on its own
	crde_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ready(push_ready),
		.push_job  (push_job),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_job   (pop_job)
	);

	crde_back #(
		.CANVAS_COLS(CANVAS_COLS),
		.CANVAS_ROWS(CANVAS_ROWS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (pop_valid),
		.q_pop        (pop),
		.q_job        (pop_job),
		.clearing     (clearing),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_color   (read_color),
		.out_of_canvas(out_of_canvas)
	);

endmodule

FILE: design/crde_ram.sv
module crde_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/crde_queue.sv
`include "clipped_rectangle_draw_engine_core_defines.svh"

module crde_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            push_ready,
	input  crde_pkg::job_t  push_job,
	output logic            pop_valid,
	input  logic            pop,
	output crde_pkg::job_t  pop_job
);

	localparam int DEPTH = crde_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	crde_pkg::job_t   slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_job    = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	`CRDE_ASSERT(a_q_no_overfill, count_q <= CNT_W'(DEPTH), "queue fill beyond depth")

endmodule

FILE: design/crde_front.sv
`include "clipped_rectangle_draw_engine_core_defines.svh"

module crde_front #(
	parameter int CANVAS_COLS = crde_pkg::DEF_CANVAS_COLS,
	parameter int CANVAS_ROWS = crde_pkg::DEF_CANVAS_ROWS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         clearing,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [crde_pkg::CMD_W-1:0]   cmd,
	input  logic [crde_pkg::FIELD_W-1:0] origin_x,
	input  logic [crde_pkg::FIELD_W-1:0] origin_y,
	input  logic [crde_pkg::FIELD_W-1:0] rect_width,
	input  logic [crde_pkg::FIELD_W-1:0] rect_height,
	input  logic [crde_pkg::COLOR_W-1:0] paint_color,
	output logic                         push,
	input  logic                         push_ready,
	output crde_pkg::job_t               push_job
);

	localparam int SW = crde_pkg::SUM_W;
	localparam int CW = crde_pkg::COORD_W;
	localparam logic [SW-1:0] COLS_S = SW'(CANVAS_COLS);
	localparam logic [SW-1:0] ROWS_S = SW'(CANVAS_ROWS);

	localparam logic [1:0] SEG_TOP    = 2'd0;
	localparam logic [1:0] SEG_BOTTOM = 2'd1;
	localparam logic [1:0] SEG_LEFT   = 2'd2;
	localparam logic [1:0] SEG_RIGHT  = 2'd3;

	logic                         busy_q;
	logic [1:0]                   seg_q;
	crde_pkg::cmd_t               cmd_q;
	logic [SW-1:0]                x_q;
	logic [SW-1:0]                y_q;
	logic [SW-1:0]                w_q;
	logic [SW-1:0]                h_q;
	logic [crde_pkg::COLOR_W-1:0] color_q;

	logic          accept;
	logic          last;
	logic          draw;
	logic          on_canvas;
	logic [SW-1:0] sx, ex, sy, ey, ex_c, ey_c;

	assign in_ready = !busy_q && !clearing;
	assign accept   = in_valid && in_ready;
	assign push     = busy_q;
	assign last     = (cmd_q != crde_pkg::CMD_BORDER) || (seg_q == SEG_RIGHT);
	assign draw     = ((cmd_q == crde_pkg::CMD_FILL) || (cmd_q == crde_pkg::CMD_BORDER)) &&
		(w_q != '0) && (h_q != '0);

	// span of the current segment, before clipping; ends are exclusive
	always_comb begin
		sx = x_q;
		ex = x_q + w_q;
		sy = y_q;
		ey = y_q + h_q;
		case (cmd_q)
			crde_pkg::CMD_BORDER: begin
				case (seg_q)
					SEG_TOP: begin
						ey = y_q + SW'(1);
					end
					SEG_BOTTOM: begin
						sy = y_q + h_q - SW'(1);
						ey = y_q + h_q;
					end
					SEG_LEFT: begin
						ex = x_q + SW'(1);
					end
					SEG_RIGHT: begin
						sx = x_q + w_q - SW'(1);
						ex = x_q + w_q;
					end
					default: begin
						ex = x_q + w_q;
					end
				endcase
			end
			default: begin
				ex = x_q + w_q;
			end
		endcase
	end

	assign on_canvas = (sx < COLS_S) && (sy < ROWS_S);
	assign ex_c      = (ex > COLS_S) ? COLS_S : ex;
	assign ey_c      = (ey > ROWS_S) ? ROWS_S : ey;

	always_comb begin
		push_job.last    = last;
		push_job.outside = (cmd_q == crde_pkg::CMD_READ) && !on_canvas;
		push_job.x0      = CW'(sx);
		push_job.x1      = CW'(ex_c);
		push_job.y0      = CW'(sy);
		push_job.y1      = CW'(ey_c);
		push_job.color   = color_q;
		if (cmd_q == crde_pkg::CMD_READ) begin
			push_job.op = crde_pkg::OP_READ;
		end else if (draw && on_canvas) begin
			push_job.op = crde_pkg::OP_PAINT;
		end else begin
			push_job.op = crde_pkg::OP_SKIP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			seg_q  <= SEG_TOP;
		end else if (accept) begin
			busy_q <= 1'b1;
			seg_q  <= SEG_TOP;
		end else if (busy_q && push_ready) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				seg_q <= seg_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= crde_pkg::cmd_t'(cmd);
			x_q     <= SW'(origin_x);
			y_q     <= SW'(origin_y);
			w_q     <= SW'(rect_width);
			h_q     <= SW'(rect_height);
			color_q <= paint_color;
		end
	end

	`CRDE_ASSERT(a_front_done_on_last, $fell(busy_q) |-> $past(push_ready && last), "front idle without last job")

endmodule

FILE: design/crde_back.sv
`include "clipped_rectangle_draw_engine_core_defines.svh"

module crde_back #(
	parameter int CANVAS_COLS = crde_pkg::DEF_CANVAS_COLS,
	parameter int CANVAS_ROWS = crde_pkg::DEF_CANVAS_ROWS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	output logic                         q_pop,
	input  crde_pkg::job_t               q_job,
	output logic                         clearing,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [crde_pkg::COLOR_W-1:0] read_color,
	output logic                         out_of_canvas
);

	localparam int DEPTH  = CANVAS_COLS * CANVAS_ROWS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CW     = crde_pkg::COORD_W;
	localparam int PW     = crde_pkg::COLOR_W;
	localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(CANVAS_COLS);
	localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(DEPTH - 1);

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_BASE   = 7'b0000100,
		ST_PAINT  = 7'b0001000,
		ST_RISSUE = 7'b0010000,
		ST_RCAPT  = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t              state_q;
	state_t              state_d;
	logic [ADDR_W-1:0]   clr_q;
	logic                out_valid_q;
	crde_pkg::job_t      job_q;
	logic [ADDR_W-1:0]   row_base_q;
	logic [CW-1:0]       col_q;
	logic [CW-1:0]       row_q;
	logic [PW-1:0]       res_data_q;
	logic                res_out_q;
	logic [PW-1:0]       read_color_q;
	logic                out_of_canvas_q;

	logic                slot_free;
	logic                row_end;
	logic                rect_end;
	logic [ADDR_W-1:0]   pix_addr;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [PW-1:0]       ram_wdata;
	logic [PW-1:0]       ram_rdata;

	assign clearing      = (state_q == ST_CLEAR);
	assign q_pop         = (state_q == ST_IDLE);
	assign slot_free     = !out_valid_q || out_ready;
	assign row_end       = (col_q + CW'(1)) == job_q.x1;
	assign rect_end      = row_end && ((row_q + CW'(1)) == job_q.y1);
	assign pix_addr      = row_base_q + ADDR_W'(col_q);
	assign out_valid     = out_valid_q;
	assign read_color    = read_color_q;
	assign out_of_canvas = out_of_canvas_q;

	assign ram_we    = clearing || (state_q == ST_PAINT);
	assign ram_waddr = clearing ? clr_q : pix_addr;
	assign ram_wdata = clearing ? '0 : job_q.color;

	crde_ram #(
		.WIDTH(PW),
		.DEPTH(DEPTH)
	) u_frame_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (state_q == ST_RISSUE),
		.raddr(pix_addr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_A) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					case (q_job.op)
						crde_pkg::OP_PAINT: state_d = ST_BASE;
						crde_pkg::OP_READ:  state_d = q_job.outside ? ST_DONE : ST_BASE;
						default:            state_d = q_job.last ? ST_DONE : ST_IDLE;
					endcase
				end
			end
			ST_BASE: begin
				state_d = (job_q.op == crde_pkg::OP_READ) ? ST_RISSUE : ST_PAINT;
			end
			ST_PAINT: begin
				if (rect_end) begin
					state_d = job_q.last ? ST_DONE : ST_IDLE;
				end
			end
			ST_RISSUE: state_d = ST_RCAPT;
			ST_RCAPT:  state_d = ST_DONE;
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (state_q == ST_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					job_q      <= q_job;
					res_data_q <= '0;
					res_out_q  <= q_job.outside;
				end
			end
			ST_BASE: begin
				row_base_q <= ADDR_W'(32'(job_q.y0) * 32'(CANVAS_COLS));
				col_q      <= job_q.x0;
				row_q      <= job_q.y0;
			end
			ST_PAINT: begin
				if (row_end) begin
					col_q      <= job_q.x0;
					row_q      <= row_q + CW'(1);
					row_base_q <= row_base_q + COLS_A;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			ST_RCAPT: begin
				res_data_q <= ram_rdata;
			end
			ST_DONE: begin
				if (slot_free) begin
					read_color_q    <= res_data_q;
					out_of_canvas_q <= res_out_q;
				end
			end
			default: begin
				res_out_q <= res_out_q;
			end
		endcase
	end

	`CRDE_ASSERT(a_paint_in_span, (state_q == ST_PAINT) |-> (col_q < job_q.x1 && row_q < job_q.y1), "paint beyond clipped span")
	`CRDE_ASSERT_NEXT(a_clear_once, state_q != ST_CLEAR, state_q != ST_CLEAR, "clear pass restarted")

endmodule
